@@ rtl/frame_bitmap_allocator_defines.svh @@
// Assertion macros shared by the allocator RTL.
`ifndef FRAME_BITMAP_ALLOCATOR_DEFINES_SVH
`define FRAME_BITMAP_ALLOCATOR_DEFINES_SVH

`ifndef ASSERT_OFF
`define FBA_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("frame allocator check failed");
`define FBA_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("frame allocator check failed");
`else
`define FBA_ASSERT(name, clk, rstn, prop)
`define FBA_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

@@ rtl/fba_pkg.sv @@
`timescale 1ns / 1ps

package fba_pkg;

  localparam int unsigned CMD_W       = 2;
  localparam int unsigned FRAME_W     = 17;
  localparam int unsigned CNT_W       = 18;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MARK  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  // register select is paddr bit 2
  localparam logic REG_FRAME_COUNT = 1'b0;
  localparam logic REG_RESERVED    = 1'b1;

  localparam logic [CNT_W-1:0] FRAME_COUNT_RST = 18'd131072;
  localparam logic [CNT_W-1:0] RESERVED_RST    = 18'd2048;

endpackage

@@ rtl/frame_bitmap_allocator.sv @@
// Each item goes from idle to the result state; a granted allocate passes the summary read
// and the bitmap read-modify-write, an in-range free or mark the bitmap read-modify-write.
// No new item is taken until the result is registered; that waits for m_axis_tready if the
// previous result is still held in the output register.
// Reset and every register write start a clearing pass over 32*max(2, ceil(MAP_WORDS/32))
// bitmap words (4096 by default), one bitmap word a cycle, during which no item is taken.
`timescale 1ns / 1ps
`include "frame_bitmap_allocator_defines.svh"

module frame_bitmap_allocator #(
  parameter int unsigned MAP_WORDS = 4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [1:0] command, [18:2] frame number, rest zero
  input  logic [fba_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [16:0] granted_frame, [18:17] status, [36:19] free count, rest zero
  output logic [fba_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fba_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [fba_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [fba_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);
  import fba_pkg::*;

  localparam int unsigned GRP_RAW = (MAP_WORDS + 31) / 32;
  localparam int unsigned GROUPS  = (GRP_RAW < 2) ? 2 : GRP_RAW;
  localparam int unsigned GA      = $clog2(GROUPS);
  localparam int unsigned WAW     = GA + 5;
  localparam int unsigned DEPTH   = GROUPS * 32;
  localparam int unsigned CAP     = MAP_WORDS * 32;
  localparam int unsigned FXW     = (WAW + 5 > CNT_W) ? WAW + 5 : CNT_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ASUM  = 3'd2;
  localparam logic [2:0] S_AWR   = 3'd3;
  localparam logic [2:0] S_FRD   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  // configuration
  logic [CNT_W-1:0] frame_count_q, reserved_q;
  logic [CNT_W-1:0] lim, span;
  logic [FXW-1:0]   lim_x, res_x;
  logic             cfg_we;

  // memories
  logic [31:0]    bm_mem [DEPTH];
  logic [31:0]    sum_mem [GROUPS];
  logic           bm_we, bm_re, sum_we, sum_re;
  logic [WAW-1:0] bm_waddr, bm_raddr;
  logic [GA-1:0]  sum_waddr, sum_raddr;
  logic [31:0]    bm_wdata, sum_wdata, bm_rdata_q, sum_rdata_q;

  // control and item state
  logic [2:0]          state_q, state_d;
  logic [WAW-1:0]      clr_q, clr_d;
  logic [30:0]         acc_q, acc_d;
  logic [CNT_W-1:0]    used_q, used_d;
  logic [GROUPS-1:0]   gfull_q, gfull_d;
  logic [CMD_W-1:0]    cmd_q, cmd_d;
  logic [FRAME_W-1:0]  fidx_q, fidx_d;
  logic [GA-1:0]       grp_q, grp_d;
  logic [4:0]          wsub_q, wsub_d;
  logic [31:0]         sumw_q, sumw_d;
  logic [FRAME_W-1:0]  granted_q, granted_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic                m_valid_q, m_valid_d;
  logic [OUT_TDATA_W-1:0] m_data_q, m_data_d;

  // datapath helpers
  logic [CMD_W-1:0]   in_cmd;
  logic [FRAME_W-1:0] in_f;
  logic [FXW-1:0]     in_fx, fq_x, alloc_frame_x;
  logic [WAW-1:0]     in_word, fq_word, alloc_word;
  logic               in_range;
  logic               grant_ok;
  logic [GA-1:0]      lz_grp;
  logic [4:0]         bit_pos, lz_word;
  logic [31:0]        bm_new, sum_new, clr_mask_w;
  logic               was_used;

  function automatic logic [31:0] low_mask(input logic [5:0] n);
    logic [31:0] m;
    m = n[5] ? 32'hFFFF_FFFF : ((32'(1) << n[4:0]) - 32'(1));
    return m;
  endfunction

  function automatic logic [4:0] low_zero32(input logic [31:0] v);
    logic [4:0] idx;
    idx = '0;
    for (int i = 31; i >= 0; i--) begin
      if (!v[i]) idx = 5'(i);
    end
    return idx;
  endfunction

  function automatic logic [GA-1:0] low_zero_grp(input logic [GROUPS-1:0] v);
    logic [GA-1:0] idx;
    idx = '0;
    for (int i = GROUPS - 1; i >= 0; i--) begin
      if (!v[i]) idx = GA'(i);
    end
    return idx;
  endfunction

  // in-range bits of word w
  function automatic logic [31:0] valid_mask(input logic [WAW-1:0] w,
                                             input logic [FXW-1:0] lx,
                                             input logic [FXW-1:0] rx);
    logic [FXW-1:0] base, dhi, dlo;
    logic [5:0]     hi, lo;
    logic [31:0]    m;
    base = FXW'({w, 5'b0});
    dhi  = lx - base;
    dlo  = (rx > base) ? rx - base : '0;
    hi   = (dhi >= FXW'(32)) ? 6'd32 : dhi[5:0];
    lo   = (dlo >= FXW'(32)) ? 6'd32 : dlo[5:0];
    if (lx <= base || lo >= hi) m = '0;
    else m = low_mask(hi) & ~low_mask(lo);
    return m;
  endfunction

  assign lim   = (CAP > 32'h3FFFF || frame_count_q < CNT_W'(CAP)) ? frame_count_q
                                                                  : CNT_W'(CAP);
  assign span  = (lim > reserved_q) ? lim - reserved_q : '0;
  assign lim_x = FXW'(lim);
  assign res_x = FXW'(reserved_q);

  // APB
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;
  always_comb begin
    unique case (paddr[2])
      REG_FRAME_COUNT: prdata = APB_DATA_W'(frame_count_q);
      REG_RESERVED:    prdata = APB_DATA_W'(reserved_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= FRAME_COUNT_RST;
      reserved_q    <= RESERVED_RST;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_FRAME_COUNT: frame_count_q <= pwdata[CNT_W-1:0];
        REG_RESERVED:    reserved_q    <= pwdata[CNT_W-1:0];
        default:         ;
      endcase
    end
  end

  assign in_cmd   = s_axis_tdata[1:0];
  assign in_f     = s_axis_tdata[FRAME_W+1:2];
  assign in_fx    = FXW'(in_f);
  assign in_word  = in_fx[WAW+4:5];
  assign in_range = (in_fx >= res_x) && (in_fx < lim_x);
  assign lz_grp   = low_zero_grp(gfull_q);

  assign fq_x       = FXW'(fidx_q);
  assign fq_word    = fq_x[WAW+4:5];
  assign lz_word    = low_zero32(sum_rdata_q);
  assign bit_pos    = low_zero32(bm_rdata_q);
  assign alloc_word = {grp_q, wsub_q};
  assign alloc_frame_x = FXW'({alloc_word, bit_pos});
  assign grant_ok   = (alloc_frame_x >= res_x) && (alloc_frame_x < lim_x);
  assign was_used   = bm_rdata_q[fidx_q[4:0]];
  assign clr_mask_w = valid_mask(clr_q, lim_x, res_x);

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    acc_d     = acc_q;
    used_d    = used_q;
    gfull_d   = gfull_q;
    cmd_d     = cmd_q;
    fidx_d    = fidx_q;
    grp_d     = grp_q;
    wsub_d    = wsub_q;
    sumw_d    = sumw_q;
    granted_d = granted_q;
    status_d  = status_q;
    m_valid_d = m_valid_q & ~m_axis_tready;
    m_data_d  = m_data_q;
    bm_we     = 1'b0;
    bm_waddr  = clr_q;
    bm_wdata  = '0;
    bm_re     = 1'b0;
    bm_raddr  = in_word;
    sum_we    = 1'b0;
    sum_waddr = grp_q;
    sum_wdata = '0;
    sum_re    = 1'b0;
    sum_raddr = in_word[WAW-1:5];
    bm_new    = '0;
    sum_new   = '0;

    unique case (state_q)
      S_CLEAR: begin
        // out-of-range bits are stored as used so a full word is all ones
        bm_we    = 1'b1;
        bm_waddr = clr_q;
        bm_wdata = ~clr_mask_w;
        if (clr_q[4:0] == 5'd31) begin
          sum_we    = 1'b1;
          sum_waddr = clr_q[WAW-1:5];
          sum_wdata = {(clr_mask_w == '0), acc_q};
          gfull_d[clr_q[WAW-1:5]] = (clr_mask_w == '0) & (&acc_q);
        end else begin
          acc_d[clr_q[4:0]] = (clr_mask_w == '0);
        end
        if (clr_q == WAW'(DEPTH - 1)) state_d = S_IDLE;
        clr_d = clr_q + WAW'(1);
      end
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d     = in_cmd;
          fidx_d    = in_f;
          granted_d = '0;
          status_d  = ST_OK;
          state_d   = S_DONE;
          case (in_cmd) inside
            CMD_ALLOC: begin
              if (&gfull_q) begin
                status_d = ST_FULL;
              end else begin
                sum_re    = 1'b1;
                sum_raddr = lz_grp;
                grp_d     = lz_grp;
                state_d   = S_ASUM;
              end
            end
            CMD_FREE, CMD_MARK: begin
              if (!in_range) begin
                status_d = ST_RANGE;
              end else begin
                bm_re     = 1'b1;
                bm_raddr  = in_word;
                sum_re    = 1'b1;
                sum_raddr = in_word[WAW-1:5];
                grp_d     = in_word[WAW-1:5];
                state_d   = S_FRD;
              end
            end
            default: ;
          endcase
        end
      end
      S_ASUM: begin
        wsub_d   = lz_word;
        sumw_d   = sum_rdata_q;
        bm_re    = 1'b1;
        bm_raddr = {grp_q, lz_word};
        state_d  = S_AWR;
      end
      S_AWR: begin
        bm_new    = bm_rdata_q | (32'(1) << bit_pos);
        bm_we     = 1'b1;
        bm_waddr  = alloc_word;
        bm_wdata  = bm_new;
        sum_new   = sumw_q | (32'(1) << wsub_q);
        if (&bm_new) begin
          sum_we    = 1'b1;
          sum_waddr = grp_q;
          sum_wdata = sum_new;
          if (&sum_new) gfull_d[grp_q] = 1'b1;
        end
        used_d    = used_q + CNT_W'(1);
        granted_d = alloc_frame_x[FRAME_W-1:0];
        state_d   = S_DONE;
      end
      S_FRD: begin
        sum_waddr = grp_q;
        bm_waddr  = fq_word;
        if (cmd_q == CMD_FREE && was_used) begin
          bm_new    = bm_rdata_q & ~(32'(1) << fidx_q[4:0]);
          bm_we     = 1'b1;
          bm_wdata  = bm_new;
          sum_we    = 1'b1;
          sum_wdata = sum_rdata_q & ~(32'(1) << fq_word[4:0]);
          gfull_d[grp_q] = 1'b0;
          used_d    = used_q - CNT_W'(1);
        end else if (cmd_q == CMD_MARK && !was_used) begin
          bm_new    = bm_rdata_q | (32'(1) << fidx_q[4:0]);
          bm_we     = 1'b1;
          bm_wdata  = bm_new;
          sum_new   = sum_rdata_q | (32'(1) << fq_word[4:0]);
          if (&bm_new) begin
            sum_we    = 1'b1;
            sum_wdata = sum_new;
            if (&sum_new) gfull_d[grp_q] = 1'b1;
          end
          used_d    = used_q + CNT_W'(1);
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_data_d  = OUT_TDATA_W'({span - used_q, status_q, granted_q});
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase

    if (cfg_we) begin
      state_d = S_CLEAR;
      clr_d   = '0;
      used_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      used_q    <= '0;
      gfull_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      used_q    <= used_d;
      gfull_q   <= gfull_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    cmd_q     <= cmd_d;
    fidx_q    <= fidx_d;
    grp_q     <= grp_d;
    wsub_q    <= wsub_d;
    sumw_q    <= sumw_d;
    granted_q <= granted_d;
    status_q  <= status_d;
    m_data_q  <= m_data_d;
  end

  always_ff @(posedge clk_i) begin
    if (bm_we) bm_mem[bm_waddr] <= bm_wdata;
    if (bm_re) bm_rdata_q <= bm_mem[bm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) sum_mem[sum_waddr] <= sum_wdata;
    if (sum_re) sum_rdata_q <= sum_mem[sum_raddr];
  end

  `FBA_ASSERT(a_used_le_span, clk_i, rst_ni, used_q <= span)
  `FBA_ASSERT(a_sum_has_room, clk_i, rst_ni, (state_q == S_ASUM) |-> !(&sum_rdata_q))
  `FBA_ASSERT(a_word_has_room, clk_i, rst_ni, (state_q == S_AWR) |-> !(&bm_rdata_q))
  `FBA_ASSERT(a_grant_in_range, clk_i, rst_ni, (state_q == S_AWR) |-> grant_ok)
  `FBA_ASSERT_ALWAYS(a_no_take_in_clear, clk_i, (state_q == S_CLEAR) |-> !s_axis_tready)

endmodule
